>>> sv/c_subset_lexer_defines.svh
// ----------------------------------------------------------------------------
// c_subset_lexer_defines.svh
// Assertion macros used by the lexer's checker file.
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CSL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c_subset_lexer check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CSL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c_subset_lexer check failed");

`endif

>>> sv/c_sl_pkg.sv
// ----------------------------------------------------------------------------
// c_sl_pkg
// Token record, token kind codes and keyword tables of the lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package c_sl_pkg;

    localparam int KIND_W   = 5;
    localparam int LINE_W   = 16;
    localparam int OFFSET_W = 24;
    localparam int LEN_W    = 8;
    localparam int KW_COUNT = 10;
    localparam int TDATA_W  = 48;
    localparam int TUSER_W  = 6;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    localparam logic [KIND_W-1:0] KIND_END     = 5'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd1;
    localparam logic [KIND_W-1:0] KIND_INTLIT  = 5'd2;
    localparam logic [KIND_W-1:0] KIND_KW0     = 5'd3;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd13;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd14;
    localparam logic [KIND_W-1:0] KIND_STAR    = 5'd15;
    localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd16;
    localparam logic [KIND_W-1:0] KIND_EQEQ    = 5'd17;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd18;
    localparam logic [KIND_W-1:0] KIND_LE      = 5'd19;
    localparam logic [KIND_W-1:0] KIND_LESS    = 5'd20;
    localparam logic [KIND_W-1:0] KIND_GE      = 5'd21;
    localparam logic [KIND_W-1:0] KIND_GREATER = 5'd22;
    localparam logic [KIND_W-1:0] KIND_NE      = 5'd23;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd24;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd25;
    localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd26;
    localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd27;
    localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd28;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd29;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 5'd30;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [KW_COUNT-1:0] kw_match;
        logic [LINE_W-1:0]   line;
        logic [OFFSET_W-1:0] start;
        logic [LEN_W-1:0]    length;
        logic                too_long;
        logic                last;
    } tok_t;

    typedef struct packed {
        logic [1:0] count;
        tok_t       tok0;
        tok_t       tok1;
    } push_t;

    function automatic logic [2:0] kw_len(input int k);
        logic [2:0] r;
        case (k)
            0:       r = 3'd3;
            1:       r = 3'd4;
            2:       r = 3'd5;
            3:       r = 3'd6;
            4:       r = 3'd4;
            5:       r = 3'd2;
            6:       r = 3'd4;
            7:       r = 3'd5;
            8:       r = 3'd3;
            9:       r = 3'd6;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // The strings are written backwards so that character 0 sits in the low byte.
    function automatic logic [63:0] kw_word(input int k);
        logic [63:0] r;
        case (k)
            0:       r = 64'("tni");
            1:       r = 64'("rahc");
            2:       r = 64'("taolf");
            3:       r = 64'("gnirts");
            4:       r = 64'("diov");
            5:       r = 64'("fi");
            6:       r = 64'("esle");
            7:       r = 64'("elihw");
            8:       r = 64'("rof");
            9:       r = 64'("nruter");
            default: r = 64'd0;
        endcase
        return r;
    endfunction

    // Clears every keyword that cannot hold character c at position idx.
    function automatic logic [KW_COUNT-1:0] kw_step(input logic [KW_COUNT-1:0] kw,
                                                    input logic [2:0] idx,
                                                    input logic [7:0] c);
        logic [KW_COUNT-1:0] r;
        logic [63:0]         w;
        r = kw;
        for (int k = 0; k < KW_COUNT; k++) begin
            w = kw_word(k);
            if (idx >= kw_len(k) || w[{idx, 3'b000} +: 8] != c)
            begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] resolve_kind(input logic [KIND_W-1:0] kind,
                                                       input logic [KW_COUNT-1:0] kw,
                                                       input logic [LEN_W-1:0] len);
        logic [KIND_W-1:0] r;
        r = kind;
        if (kind == KIND_IDENT)
        begin
            for (int k = KW_COUNT - 1; k >= 0; k--) begin
                if (kw[k] && len == {5'b00000, kw_len(k)})
                begin
                    r = KIND_KW0 + KIND_W'(k);
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/c_sl_front.sv
// ----------------------------------------------------------------------------
// c_sl_front
// Scanner: takes one source byte per transaction, tracks the lexeme in
// progress and hands zero, one or two raw token records to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module c_sl_front
    import c_sl_pkg::*;
#(
    parameter int MAX_LEXEME  = 255,
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 24
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    input  wire logic       accept,
    output push_t           push
);

    localparam int LEN_CNT_W  = $clog2(MAX_LEXEME + 1);
    localparam int LEN_WIDE_W = LEN_CNT_W + LEN_W;
    localparam int LINE_WIDE  = LINE_BITS + LINE_W;
    localparam int OFF_WIDE   = OFFSET_BITS + OFFSET_W;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_EQ,
        MODE_LT,
        MODE_GT,
        MODE_BANG,
        MODE_ERR
    } mode_t;

    mode_t                  mode_reg,  mode_next;
    logic [KW_COUNT-1:0]    kw_reg,    kw_next;
    logic [LEN_CNT_W-1:0]   len_reg,   len_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LINE_BITS-1:0]   tline_reg, tline_next;
    logic [LINE_BITS-1:0]   line_reg,  line_next;
    logic [OFFSET_BITS-1:0] off_reg,   off_next;
    logic                   ovf_reg,   ovf_next;

    logic                  is_alpha, is_digit, is_space;
    logic [LEN_WIDE_W-1:0] len_wide;
    logic [LEN_W-1:0]      len_cap;
    logic [2:0]            kw_idx;
    logic                  len_room;
    logic [LINE_WIDE-1:0]  line_wide, tline_wide;
    logic [OFF_WIDE-1:0]   off_wide, start_wide;
    logic [LINE_W-1:0]     line16, tline16;
    logic [OFFSET_W-1:0]   off24, start24;
    logic [KW_COUNT-1:0]   kw_first, kw_ext;

    // Outcome of treating the current byte as the first byte after a token.
    logic        idl_emit, idl_begin, idl_nl;
    mode_t       idl_mode;
    tok_t        idl_tok;

    logic        use_idle, has_a, has_b;
    tok_t        tok_a, tok_b, run_tok, single_tok;
    push_t       push_c;

    function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind,
                                    input logic [LINE_W-1:0] line,
                                    input logic [OFFSET_W-1:0] start,
                                    input logic [LEN_W-1:0] len,
                                    input logic tl,
                                    input logic [KW_COUNT-1:0] kw);
        tok_t t;
        t.kind     = kind;
        t.kw_match = kw;
        t.line     = line;
        t.start    = start;
        t.length   = len;
        t.too_long = tl;
        t.last     = 1'b0;
        return t;
    endfunction

    assign is_alpha = (text_byte >= "a" && text_byte <= "z") ||
                      (text_byte >= "A" && text_byte <= "Z") || text_byte == "_";
    assign is_digit = text_byte >= "0" && text_byte <= "9";
    assign is_space = text_byte == 8'h20 || (text_byte >= 8'h09 && text_byte <= 8'h0D);

    assign len_wide = LEN_WIDE_W'(len_reg);
    assign len_cap  = (len_wide > LEN_WIDE_W'(255)) ? 8'hFF : len_wide[LEN_W-1:0];
    assign kw_idx   = (len_wide >= LEN_WIDE_W'(7)) ? 3'd7 : len_wide[2:0];
    assign len_room = len_reg < LEN_CNT_W'(MAX_LEXEME);

    assign line_wide  = LINE_WIDE'(line_reg);
    assign tline_wide = LINE_WIDE'(tline_reg);
    assign off_wide   = OFF_WIDE'(off_reg);
    assign start_wide = OFF_WIDE'(start_reg);
    assign line16     = line_wide[LINE_W-1:0];
    assign tline16    = tline_wide[LINE_W-1:0];
    assign off24      = off_wide[OFFSET_W-1:0];
    assign start24    = start_wide[OFFSET_W-1:0];

    assign kw_first = kw_step({KW_COUNT{1'b1}}, 3'd0, text_byte);
    assign kw_ext   = kw_step(kw_reg, kw_idx, text_byte);

    always_comb
    begin
        logic [KIND_W-1:0] op_kind;
        idl_emit  = 1'b0;
        idl_begin = 1'b0;
        idl_nl    = 1'b0;
        idl_mode  = MODE_IDLE;
        op_kind   = KIND_ERROR;
        if (is_space)
        begin
            idl_nl = text_byte == 8'h0A;
        end
        else if (is_alpha)
        begin
            idl_mode  = MODE_WORD;
            idl_begin = 1'b1;
        end
        else if (is_digit)
        begin
            idl_mode  = MODE_NUM;
            idl_begin = 1'b1;
        end
        else
        begin
            case (text_byte)
                "=":
                begin
                    idl_mode  = MODE_EQ;
                    idl_begin = 1'b1;
                end
                "<":
                begin
                    idl_mode  = MODE_LT;
                    idl_begin = 1'b1;
                end
                ">":
                begin
                    idl_mode  = MODE_GT;
                    idl_begin = 1'b1;
                end
                "!":
                begin
                    idl_mode  = MODE_BANG;
                    idl_begin = 1'b1;
                end
                "+":     begin idl_emit = 1'b1; op_kind = KIND_PLUS;   end
                "-":     begin idl_emit = 1'b1; op_kind = KIND_MINUS;  end
                "*":     begin idl_emit = 1'b1; op_kind = KIND_STAR;   end
                "/":     begin idl_emit = 1'b1; op_kind = KIND_SLASH;  end
                "(":     begin idl_emit = 1'b1; op_kind = KIND_LPAREN; end
                ")":     begin idl_emit = 1'b1; op_kind = KIND_RPAREN; end
                "{":     begin idl_emit = 1'b1; op_kind = KIND_LBRACE; end
                "}":     begin idl_emit = 1'b1; op_kind = KIND_RBRACE; end
                ";":     begin idl_emit = 1'b1; op_kind = KIND_SEMI;   end
                ",":     begin idl_emit = 1'b1; op_kind = KIND_COMMA;  end
                default:
                begin
                    idl_emit = 1'b1;
                    idl_mode = MODE_ERR;
                end
            endcase
        end
        idl_tok = mk_tok(op_kind, line16, off24, 8'd1, 1'b0, '0);
    end

    always_comb
    begin
        logic [KIND_W-1:0] single_kind;
        case (mode_reg)
            MODE_EQ:  single_kind = KIND_ASSIGN;
            MODE_LT:  single_kind = KIND_LESS;
            MODE_GT:  single_kind = KIND_GREATER;
            default:  single_kind = KIND_ERROR;
        endcase
        single_tok = mk_tok(single_kind, tline16, start24, 8'd1, 1'b0, '0);
        run_tok    = mk_tok((mode_reg == MODE_WORD) ? KIND_IDENT : KIND_INTLIT, tline16,
                            start24, len_cap, ovf_reg,
                            (mode_reg == MODE_WORD) ? kw_reg : '0);
    end

    always_comb
    begin
        logic [KIND_W-1:0] double_kind;
        mode_next  = mode_reg;
        kw_next    = kw_reg;
        len_next   = len_reg;
        start_next = start_reg;
        tline_next = tline_reg;
        line_next  = line_reg;
        off_next   = off_reg;
        ovf_next   = ovf_reg;
        use_idle   = 1'b0;
        has_a      = 1'b0;
        has_b      = 1'b0;
        tok_a      = run_tok;
        tok_b      = idl_tok;

        case (mode_reg)
            MODE_LT:  double_kind = KIND_LE;
            MODE_GT:  double_kind = KIND_GE;
            MODE_BANG: double_kind = KIND_NE;
            default:  double_kind = KIND_EQEQ;
        endcase

        if (end_of_text)
        begin
            case (mode_reg)
                MODE_WORD, MODE_NUM:
                begin
                    has_a = 1'b1;
                end
                MODE_EQ, MODE_LT, MODE_GT, MODE_BANG:
                begin
                    has_a = 1'b1;
                    tok_a = single_tok;
                end
                default:
                begin
                    has_a = 1'b0;
                end
            endcase
            has_b      = 1'b1;
            tok_b      = mk_tok(KIND_END, line16, off24, 8'd0, 1'b0, '0);
            mode_next  = MODE_IDLE;
            kw_next    = {KW_COUNT{1'b1}};
            len_next   = '0;
            start_next = '0;
            tline_next = LINE_BITS'(1);
            line_next  = LINE_BITS'(1);
            off_next   = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            off_next = off_reg + OFFSET_BITS'(1);
            case (mode_reg)
                MODE_WORD, MODE_NUM:
                begin
                    if (is_digit || (is_alpha && mode_reg == MODE_WORD))
                    begin
                        if (len_room)
                        begin
                            kw_next  = kw_ext;
                            len_next = len_reg + LEN_CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                            kw_next  = '0;
                        end
                    end
                    else
                    begin
                        has_a    = 1'b1;
                        use_idle = 1'b1;
                    end
                end
                MODE_EQ, MODE_LT, MODE_GT, MODE_BANG:
                begin
                    has_a = 1'b1;
                    if (text_byte == "=")
                    begin
                        tok_a     = mk_tok(double_kind, tline16, start24, 8'd2, 1'b0, '0);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        tok_a = single_tok;
                        // A lone bang is an error; the scanner then swallows every byte up to end of text.
                        if (mode_reg == MODE_BANG)
                        begin
                            mode_next = MODE_ERR;
                        end
                        else
                        begin
                            use_idle = 1'b1;
                        end
                    end
                end
                MODE_IDLE:
                begin
                    use_idle = 1'b1;
                end
                default:
                begin
                    use_idle = 1'b0;
                end
            endcase

            if (use_idle)
            begin
                mode_next = idl_mode;
                has_b     = idl_emit;
                if (idl_begin)
                begin
                    start_next = off_reg;
                    tline_next = line_reg;
                    ovf_next   = 1'b0;
                    if (is_alpha || is_digit)
                    begin
                        len_next = LEN_CNT_W'(1);
                        kw_next  = kw_first;
                    end
                    else
                    begin
                        len_next = '0;
                        kw_next  = {KW_COUNT{1'b1}};
                    end
                end
                if (idl_nl && line_reg != {LINE_BITS{1'b1}})
                begin
                    line_next = line_reg + LINE_BITS'(1);
                end
            end
        end
    end

    always_comb
    begin
        push_c.tok0 = tok_a;
        push_c.tok1 = tok_b;
        if (has_a && has_b)
        begin
            push_c.count = 2'd2;
        end
        else if (has_a)
        begin
            push_c.count = 2'd1;
        end
        else if (has_b)
        begin
            push_c.count = 2'd1;
            push_c.tok0  = tok_b;
        end
        else
        begin
            push_c.count = 2'd0;
        end
        push_c.tok0.last = push_c.count == 2'd1;
        push_c.tok1.last = 1'b1;
        if (!accept)
        begin
            push_c.count = 2'd0;
        end
    end

    assign push = push_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            kw_reg    <= {KW_COUNT{1'b1}};
            len_reg   <= '0;
            start_reg <= '0;
            tline_reg <= LINE_BITS'(1);
            line_reg  <= LINE_BITS'(1);
            off_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            kw_reg    <= kw_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            tline_reg <= tline_next;
            line_reg  <= line_next;
            off_reg   <= off_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/c_sl_queue.sv
// ----------------------------------------------------------------------------
// c_sl_queue
// Four-entry token queue between scanner and emitter; takes up to two
// records per cycle and gives one per cycle while pop is high.
// ----------------------------------------------------------------------------
`default_nettype none

module c_sl_queue
    import c_sl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       space,
    input  wire logic  pop,
    output tok_t       head,
    output logic       head_valid
);

    tok_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg,    cnt_next;
    logic [QPTR_W-1:0] wr_ptr_second;

    assign wr_ptr_second = wr_ptr_reg + QPTR_W'(1);
    assign wr_ptr_next   = wr_ptr_reg + QPTR_W'(push.count);
    assign rd_ptr_next   = rd_ptr_reg + QPTR_W'(pop);
    assign cnt_next      = cnt_reg + QCNT_W'(push.count) - QCNT_W'(pop);

    // Room for the worst case of one byte, two tokens.
    assign space      = cnt_reg <= QCNT_W'(QDEPTH - 2);
    assign head_valid = cnt_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_second] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/c_sl_back.sv
// ----------------------------------------------------------------------------
// c_sl_back
// Emitter: resolves keywords from the match vector and drives the token
// stream from an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module c_sl_back
    import c_sl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tok_t                head,
    input  wire logic                head_valid,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata,
    output logic [TUSER_W-1:0]       m_tuser,
    output logic                     m_tlast
);

    logic                valid_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [LINE_W-1:0]   line_reg;
    logic [OFFSET_W-1:0] start_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                tl_reg;
    logic                last_reg;

    assign pop = head_valid && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || m_tready)
        begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= resolve_kind(head.kind, head.kw_match, head.length);
            line_reg  <= head.line;
            start_reg <= head.start;
            len_reg   <= head.length;
            tl_reg    <= head.too_long;
            last_reg  <= head.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {len_reg, start_reg, line_reg};
    assign m_tuser  = {tl_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> sv/c_subset_lexer.sv
// ----------------------------------------------------------------------------
// c_subset_lexer
// Lexical analyzer for a small C subset: source bytes in, tokens out.
// ----------------------------------------------------------------------------
//  Channel  | Dir | tdata                           | tuser                 | tlast
//  s_*      | in  | [7:0] text_byte                 | -                     | end_of_text
//  m_*      | out | [15:0] line [39:16] start_offset | [4:0] kind            | last
//           |     | [47:40] lexeme_length           | [5] too_long          |
//
//  One byte is taken per cycle while s_tready is high; a byte that closes
//  one token and opens another queues both records in that same cycle.
//  Tokens leave at one per cycle while m_tready is high, so the token rate of the
//  output port sets the sustained input rate; s_tready drops while the four-entry
//  queue has fewer than two free entries. Tokens pass the queue, then the output
//  register; rst_n clears scanner state and queue at once, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_lexer
    import c_sl_pkg::*;
#(
    parameter int MAX_LEXEME  = 255,
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] text_byte
    input  wire logic               s_tlast,   // end_of_text
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [15:0] line, [39:16] start_offset,
                                               // [47:40] lexeme_length
    output logic [TUSER_W-1:0]      m_tuser,   // [4:0] kind, [5] too_long
    output logic                    m_tlast    // last
);

    push_t push;
    tok_t  head;
    logic  head_valid;
    logic  pop;
    logic  space;
    logic  accept;

    assign s_tready = space;
    assign accept   = s_tvalid && space;

    c_sl_front #(
        .MAX_LEXEME  (MAX_LEXEME),
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .accept      (accept),
        .push        (push)
    );

    c_sl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space      (space),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    c_sl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

>>> sv/c_sl_checker.sv
// ----------------------------------------------------------------------------
// c_sl_checker
// Port-level checks on the token stream of the lexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "c_subset_lexer_defines.svh"

module c_sl_checker
    import c_sl_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [TUSER_W-1:0] m_tuser,
    input wire logic               m_tlast
);

    // A token waiting on the output side is not withdrawn.
    `CSL_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // The end token is always the final token of its transaction.
    `CSL_ASSERT_IMP(a_end_last, m_tvalid && m_tuser[4:0] == KIND_END, m_tlast)

    // The end token carries no lexeme.
    `CSL_ASSERT_IMP(a_end_empty, m_tvalid && m_tuser[4:0] == KIND_END,
                    m_tdata[47:40] == 8'd0 && !m_tuser[5])

    // Operators and punctuation are one or two characters long and never overlong.
    `CSL_ASSERT_IMP(a_op_len, m_tvalid && m_tuser[4:0] >= KIND_PLUS && m_tuser[4:0] <= KIND_COMMA,
                    !m_tuser[5] && (m_tdata[47:40] == 8'd1 || m_tdata[47:40] == 8'd2))

endmodule

bind c_subset_lexer c_sl_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
